// File: rtl/urcd_pkg.sv
// shared types, constants and helper functions of the uniform row/column detector
// no dependencies; compiled first
package urcd_pkg;

    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int PIX_W      = 32;
    localparam int KIND_W     = 2;
    localparam int INDEX_W    = 12;
    localparam int MASK_W     = 64;
    localparam int ROWS_W     = 13;
    localparam int COLS_W     = 12;
    localparam int IMG_W_W    = 12;
    localparam int IMG_H_W    = 13;
    localparam int BPP_W      = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 13;
    localparam int WORD_SHIFT = 6;

    localparam int RES_FIFO_DEPTH = 4;
    localparam int FIFO_CNT_W     = $clog2(RES_FIFO_DEPTH + 1);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ROW     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MASK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY = 2'd2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST     = 12'd2048;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST    = 13'd4096;
    localparam logic [BPP_W-1:0]   BYTES_PER_PIXEL_RST = 3'd4;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_value;
    } pixel_t;

    typedef struct packed {
        logic [KIND_W-1:0]  result_kind;
        logic [INDEX_W-1:0] item_index;
        logic               row_kept;
        logic [MASK_W-1:0]  column_mask;
        logic [ROWS_W-1:0]  living_rows;
        logic [COLS_W-1:0]  living_cols;
        logic               nothing_to_do;
        logic               last_of_run;
    } result_t;

    // pixel beat handed to the column tracker
    typedef struct packed {
        logic vld;
        logic first_row;
    } col_req_t;

    // frame-end mask dump control
    typedef struct packed {
        logic rd;
        logic clear;
    } dump_ctrl_t;

    function automatic logic [PIX_W-1:0] byte_mask(input logic [BPP_W-1:0] bpp);
        logic [PIX_W-1:0] m;
        case (bpp)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 4'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [6:0] popcount64(input logic [MASK_W-1:0] v);
        logic [6:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + 7'(popcount8(v[8*i +: 8]));
        end
        return n;
    endfunction

endpackage

// File: rtl/urcd_chan_if.sv
// valid/ready channel carrying one payload struct per beat
// payload type is set by the instantiating module (see urcd_pkg)
interface urcd_chan_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/urcd_col_track.sv
// column reference memory and column-alive word memory with read-modify-write
// depends on urcd_pkg
module urcd_col_track import urcd_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int NW = (MAX_WIDTH + 63) / 64,
    localparam int KW = (NW > 1) ? $clog2(NW) : 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  col_req_t         req,
    input  logic [XW-1:0]    req_x,
    input  logic [PIX_W-1:0] req_pix,
    input  logic [PIX_W-1:0] pix_mask,
    input  dump_ctrl_t       dump,
    input  logic [KW-1:0]    dump_idx,
    output logic [MASK_W-1:0] rd_word
);

    logic [PIX_W-1:0]  ref_mem [MAX_WIDTH];
    logic [MASK_W-1:0] alive_mem [NW];
    logic [NW-1:0]     alive_vld_reg;

    logic              b_vld_reg;
    logic              b_first_reg;
    logic [5:0]        b_bit_reg;
    logic [KW-1:0]     b_widx_reg;
    logic [PIX_W-1:0]  b_pix_reg;

    logic [PIX_W-1:0]  ref_q_reg;
    logic [MASK_W-1:0] word_q_reg;
    logic              word_vld_reg;
    logic              fwd_sel_reg;
    logic [MASK_W-1:0] fwd_word_reg;

    logic              rd_en;
    logic [KW-1:0]     rd_idx;
    logic [MASK_W-1:0] old_word;
    logic [MASK_W-1:0] new_word;
    logic              differs;

    assign rd_en  = req.vld | dump.rd;
    assign rd_idx = dump.rd ? dump_idx : KW'(req_x >> WORD_SHIFT);

    // a write-back at the same edge as the read is not seen by the memory
    assign old_word = fwd_sel_reg  ? fwd_word_reg :
                      word_vld_reg ? word_q_reg   : '0;
    assign differs  = !b_first_reg && (b_pix_reg != (ref_q_reg & pix_mask));
    assign new_word = old_word | (differs ? (64'd1 << b_bit_reg) : '0);
    assign rd_word  = old_word;

    always_ff @(posedge clk)
    begin
        if (req.vld)
        begin
            if (req.first_row)
            begin
                ref_mem[req_x] <= req_pix;
            end
            ref_q_reg <= ref_mem[req_x];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            word_q_reg <= alive_mem[rd_idx];
        end
        if (b_vld_reg)
        begin
            alive_mem[b_widx_reg] <= new_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.vld)
        begin
            b_first_reg <= req.first_row;
            b_bit_reg   <= req_x[5:0];
            b_widx_reg  <= KW'(req_x >> WORD_SHIFT);
            b_pix_reg   <= req_pix;
        end
        fwd_word_reg <= new_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg     <= 1'b0;
            alive_vld_reg <= '0;
            word_vld_reg  <= 1'b0;
            fwd_sel_reg   <= 1'b0;
        end
        else
        begin
            b_vld_reg <= req.vld;
            if (dump.clear)
            begin
                alive_vld_reg <= '0;
            end
            else if (b_vld_reg)
            begin
                alive_vld_reg[b_widx_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                word_vld_reg <= alive_vld_reg[rd_idx];
                fwd_sel_reg  <= b_vld_reg && (rd_idx == b_widx_reg);
            end
        end
    end

endmodule

// File: rtl/urcd_out_fifo.sv
// small result queue that decouples the detector from a stalling receiver
// depends on urcd_pkg and urcd_chan_if
module urcd_out_fifo import urcd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  result_t               push_data,
    output logic [FIFO_CNT_W-1:0] count,
    urcd_chan_if.source           result
);

    localparam int PW = (RES_FIFO_DEPTH > 1) ? $clog2(RES_FIFO_DEPTH) : 1;

    result_t                entry_reg [RES_FIFO_DEPTH];
    logic [PW-1:0]          wr_ptr_reg;
    logic [PW-1:0]          rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]  cnt_reg;
    logic                   pop;

    assign pop          = result.valid & result.ready;
    assign result.valid = (cnt_reg != '0);
    assign result.data  = entry_reg[rd_ptr_reg];
    assign count        = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(RES_FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(RES_FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

endmodule

// File: rtl/uniform_row_column_detector_top.sv
// top level of the uniform row/column detector: config, raster position, row state, dump
// depends on urcd_pkg, urcd_chan_if, urcd_col_track, urcd_out_fifo
//
// pixel: one beat per pixel in raster order; result: row verdicts, column mask words and
// the frame summary. cfg_wr_en/cfg_addr/cfg_wdata write image_width (0), image_height (1)
// and bytes_per_pixel (2); write only while no results are outstanding.
// Pixels are taken at one per cycle while pixel.ready is high. A pixel's column check
// reads the column reference and the alive word it lives in (registered memory read)
// and writes the alive word back on the next edge; a row verdict is registered in the
// column stage and then queued before it shows on result. After the last pixel of a
// frame the alive words are read out one at a time, each read in ST_RD and then masked
// and popcounted in ST_WORD, followed by the summary; pixel.ready is low meanwhile.
// Reset restores the default sizes, clears positions and counts and marks every alive
// word empty at once; no clearing pass is needed.
// A four-beat result queue absorbs receiver stalls; pixel.ready drops while the queue
// could not take the results of the pixel in flight.
module uniform_row_column_detector_top import urcd_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    urcd_chan_if.sink             pixel,
    urcd_chan_if.source           result
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int WCW  = $clog2(MAX_WIDTH + 1);
    localparam int NW   = (MAX_WIDTH + 63) / 64;
    localparam int KW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HCW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCMP = (WCW > IMG_W_W) ? WCW : IMG_W_W;
    localparam int HCMP = (HCW > IMG_H_W) ? HCW : IMG_H_W;

    typedef enum logic [3:0] {
        ST_RUN  = 4'b0001,
        ST_RD   = 4'b0010,
        ST_WORD = 4'b0100,
        ST_SUM  = 4'b1000
    } state_t;

    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    logic [BPP_W-1:0]   bpp_reg;

    logic [WCW-1:0]     w_eff;
    logic [HCW-1:0]     h_eff;
    logic [PIX_W-1:0]   pix_mask;
    logic [PIX_W-1:0]   pix;

    logic [XW-1:0]      col_pos_reg;
    logic [YW-1:0]      row_pos_reg;
    logic [PIX_W-1:0]   row_ref_reg;
    logic               row_alive_reg;
    logic [HCW-1:0]     row_cnt_reg;

    logic               b_vld_reg;
    logic               b_row_end_reg;
    logic               b_frame_end_reg;
    logic               b_kept_reg;
    logic [YW-1:0]      b_y_reg;

    state_t             state_reg;
    state_t             state_next;
    logic [KW-1:0]      k_reg;
    logic [WCW-1:0]     cols_reg;

    logic               fire;
    logic [WCW-1:0]     x_inc;
    logic [HCW-1:0]     y_inc;
    logic               row_end;
    logic               frame_end;
    logic               row_alive_now;
    logic               b_push;

    logic [FIFO_CNT_W-1:0] fifo_cnt;
    logic               room;
    logic               push;
    result_t            push_data;

    logic [WCW:0]       words;
    logic               last_word;
    logic [WCW-1:0]     rem;
    logic [MASK_W-1:0]  rem_mask;
    logic [MASK_W-1:0]  rd_word;
    logic [MASK_W-1:0]  word_masked;
    logic               nothing;

    col_req_t           col_req;
    dump_ctrl_t         dump;

    // effective sizes, out-of-range values clamped
    always_comb
    begin
        priority if (width_reg == '0)
            w_eff = WCW'(1);
        else if (WCMP'(width_reg) > WCMP'(MAX_WIDTH))
            w_eff = WCW'(MAX_WIDTH);
        else
            w_eff = WCW'(width_reg);

        priority if (height_reg == '0)
            h_eff = HCW'(1);
        else if (HCMP'(height_reg) > HCMP'(MAX_HEIGHT))
            h_eff = HCW'(MAX_HEIGHT);
        else
            h_eff = HCW'(height_reg);
    end

    assign pix_mask = byte_mask(bpp_reg);
    assign pix      = pixel.data.pixel_value & pix_mask;
    assign fire     = pixel.valid & pixel.ready;

    assign x_inc     = WCW'(col_pos_reg) + WCW'(1);
    assign y_inc     = HCW'(row_pos_reg) + HCW'(1);
    assign row_end   = !(x_inc < w_eff);
    assign frame_end = row_end && !(y_inc < h_eff);
    assign row_alive_now = (col_pos_reg == '0) ? 1'b0 :
                           (pix != row_ref_reg) ? 1'b1 : row_alive_reg;

    assign b_push = b_vld_reg && b_row_end_reg;
    assign room   = (fifo_cnt < FIFO_CNT_W'(RES_FIFO_DEPTH));

    // keep room for the verdict of the pixel now in the column stage
    assign pixel.ready = (state_reg == ST_RUN) && !(b_vld_reg && b_frame_end_reg) &&
                         ((fifo_cnt + FIFO_CNT_W'(b_push)) < FIFO_CNT_W'(RES_FIFO_DEPTH));

    assign col_req.vld       = fire;
    assign col_req.first_row = (row_pos_reg == '0);

    assign dump.rd    = (state_reg == ST_RD);
    assign dump.clear = (state_reg == ST_SUM) && room;

    urcd_col_track #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_col_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (col_req),
        .req_x    (col_pos_reg),
        .req_pix  (pix),
        .pix_mask (pix_mask),
        .dump     (dump),
        .dump_idx (k_reg),
        .rd_word  (rd_word)
    );

    // mask word readout
    assign words       = ((WCW + 1)'(w_eff) + (WCW + 1)'(63)) >> WORD_SHIFT;
    assign last_word   = ((WCW + 1)'(k_reg) + (WCW + 1)'(1)) == words;
    assign rem         = w_eff - WCW'({k_reg, 6'b0});
    assign rem_mask    = (rem >= WCW'(64)) ? {MASK_W{1'b1}} : ~({MASK_W{1'b1}} << rem[5:0]);
    assign word_masked = rd_word & rem_mask;

    assign nothing = (cols_reg == '0) || (row_cnt_reg == '0) ||
                     ((cols_reg == w_eff) && (row_cnt_reg == h_eff));

    always_comb
    begin
        push_data = '0;
        push      = 1'b0;
        unique case (state_reg)
            ST_RUN:
            begin
                push                  = b_push;
                push_data.result_kind = KIND_ROW;
                push_data.item_index  = INDEX_W'(b_y_reg);
                push_data.row_kept    = b_kept_reg;
                push_data.last_of_run = !b_frame_end_reg;
            end
            ST_WORD:
            begin
                push                  = room;
                push_data.result_kind = KIND_MASK;
                push_data.item_index  = INDEX_W'(k_reg);
                push_data.column_mask = word_masked;
            end
            ST_SUM:
            begin
                push                    = room;
                push_data.result_kind   = KIND_SUMMARY;
                push_data.living_rows   = ROWS_W'(row_cnt_reg);
                push_data.living_cols   = COLS_W'(cols_reg);
                push_data.nothing_to_do = nothing;
                push_data.last_of_run   = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (b_vld_reg && b_frame_end_reg)
                    state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_WORD;
            end
            ST_WORD:
            begin
                if (room)
                    state_next = last_word ? ST_SUM : ST_RD;
            end
            ST_SUM:
            begin
                if (room)
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    urcd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .count     (fifo_cnt),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RST;
            height_reg <= IMAGE_HEIGHT_RST;
            bpp_reg    <= BYTES_PER_PIXEL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:     width_reg  <= cfg_wdata[IMG_W_W-1:0];
                REG_IMAGE_HEIGHT:    height_reg <= cfg_wdata[IMG_H_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg    <= cfg_wdata[BPP_W-1:0];
                default:             ;
            endcase
        end
    end

    // payload of the column stage
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            b_kept_reg <= row_alive_now;
            b_y_reg    <= row_pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg     <= '0;
            row_pos_reg     <= '0;
            row_ref_reg     <= '0;
            row_alive_reg   <= 1'b0;
            row_cnt_reg     <= '0;
            b_vld_reg       <= 1'b0;
            b_row_end_reg   <= 1'b0;
            b_frame_end_reg <= 1'b0;
            state_reg       <= ST_RUN;
            k_reg           <= '0;
            cols_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            b_vld_reg       <= fire;
            b_row_end_reg   <= fire && row_end;
            b_frame_end_reg <= fire && frame_end;

            if (fire)
            begin
                if (col_pos_reg == '0)
                    row_ref_reg <= pix;
                row_alive_reg <= row_alive_now;
                col_pos_reg   <= row_end ? '0 : XW'(x_inc);
                if (row_end)
                begin
                    row_pos_reg <= frame_end ? '0 : YW'(y_inc);
                    if (row_alive_now)
                        row_cnt_reg <= row_cnt_reg + HCW'(1);
                end
            end
            else if (dump.clear)
            begin
                row_cnt_reg <= '0;
            end

            if (state_reg == ST_RUN)
            begin
                k_reg    <= '0;
                cols_reg <= '0;
            end
            else if ((state_reg == ST_WORD) && room)
            begin
                k_reg    <= k_reg + KW'(1);
                cols_reg <= cols_reg + WCW'(popcount64(word_masked));
            end
        end
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// self-checking bench for uniform_row_column_detector_top: raster frames in, verdicts,
// mask words and summaries out, checked against an in-bench detector prediction
// depends on urcd_pkg, urcd_chan_if and the detector rtl
module testbench;
    import urcd_pkg::*;

    localparam int MAX_W        = MAX_WIDTH_DEF;
    localparam int MAX_H        = MAX_HEIGHT_DEF;
    localparam int WORDS        = (MAX_W + 63) / 64;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 100;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_PIXELS = 70;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    urcd_chan_if #(.payload_t(pixel_t))  pix_if ();
    urcd_chan_if #(.payload_t(result_t)) res_if ();

    uniform_row_column_detector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .pixel     (pix_if),
        .result    (res_if)
    );

    always #4 clk = ~clk;

    // pixels waiting to be driven and results the detector still owes
    logic [PIX_W-1:0] raster_q [$];
    result_t          owed_results [$];

    int          send_idle_pct = 35;
    int          recv_idle_pct = 69;
    bit          hold_sender = 1'b0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // shadow of the detector's registers and frame state
    logic [IMG_W_W-1:0] width_reg = IMAGE_WIDTH_RST;
    logic [IMG_H_W-1:0] height_reg = IMAGE_HEIGHT_RST;
    logic [BPP_W-1:0]   bpp_reg = BYTES_PER_PIXEL_RST;
    logic [PIX_W-1:0]   col_ref [MAX_W];
    logic [MASK_W-1:0]  col_live [WORDS];
    logic [PIX_W-1:0]   row_ref = '0;
    bit                 row_live = 1'b0;
    int unsigned        col_pos = 0;
    int unsigned        row_pos = 0;
    int unsigned        live_rows = 0;

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > MAX_W)
            return MAX_W;
        return width_reg;
    endfunction

    function automatic int unsigned eff_height();
        if (height_reg == 0)
            return 1;
        if (height_reg > MAX_H)
            return MAX_H;
        return height_reg;
    endfunction

    function automatic logic [PIX_W-1:0] compare_mask();
        int unsigned n;
        n = (bpp_reg > 4) ? 4 : bpp_reg;
        if (n == 0)
            return '0;
        return 32'hFFFF_FFFF >> (32 - 8 * n);
    endfunction

    // advance the raster by one pixel and queue the results it owes
    function automatic void scan_pixel(input logic [PIX_W-1:0] raw);
        int unsigned w;
        int unsigned h;
        int unsigned x;
        int unsigned y;
        int unsigned rem;
        int unsigned cols;
        logic [PIX_W-1:0]  msk;
        logic [PIX_W-1:0]  p;
        logic [MASK_W-1:0] m;
        bit                frame_end;
        result_t           r;
        w = eff_width();
        h = eff_height();
        msk = compare_mask();
        p = raw & msk;
        x = (col_pos >= MAX_W) ? MAX_W - 1 : col_pos;
        y = row_pos;
        if (x == 0)
        begin
            row_ref = p;
            row_live = 1'b0;
        end
        else if (p != row_ref)
            row_live = 1'b1;
        if (y == 0)
            col_ref[x] = p;
        else if (p != (col_ref[x] & msk))
            col_live[x / 64][x % 64] = 1'b1;
        if (x + 1 < w)
        begin
            col_pos = x + 1;
            return;
        end
        if (row_live)
            live_rows++;
        frame_end = !(y + 1 < h);
        r = '0;
        r.result_kind = KIND_ROW;
        r.item_index = INDEX_W'(y);
        r.row_kept = row_live;
        r.last_of_run = !frame_end;
        owed_results.push_back(r);
        col_pos = 0;
        if (!frame_end)
        begin
            row_pos = y + 1;
            return;
        end
        cols = 0;
        for (int k = 0; k < (w + 63) / 64 && k < WORDS; k++)
        begin
            m = col_live[k];
            rem = w - 64 * k;
            // columns past the width are never reported
            if (rem < 64)
                m &= (64'd1 << rem) - 64'd1;
            cols += $countones(m);
            r = '0;
            r.result_kind = KIND_MASK;
            r.item_index = INDEX_W'(k);
            r.column_mask = m;
            owed_results.push_back(r);
        end
        r = '0;
        r.result_kind = KIND_SUMMARY;
        r.living_rows = ROWS_W'(live_rows);
        r.living_cols = COLS_W'(cols);
        r.nothing_to_do = (cols == 0) || (live_rows == 0) || (cols == w && live_rows == h);
        r.last_of_run = 1'b1;
        owed_results.push_back(r);
        foreach (col_live[i])
            col_live[i] = '0;
        row_pos = 0;
        live_rows = 0;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] got,
                                 input logic [63:0] want, input result_t ctx);
        if (got !== want)
            report_mismatch($sformatf("kind %0d index %0d %s got %0h want %0h",
                            ctx.result_kind, ctx.item_index, name, got, want));
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (owed_results.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result kind %0d index %0d",
                            got.result_kind, got.item_index));
            return;
        end
        want = owed_results.pop_front();
        compare_field("result_kind", got.result_kind, want.result_kind, want);
        compare_field("item_index", got.item_index, want.item_index, want);
        compare_field("row_kept", got.row_kept, want.row_kept, want);
        compare_field("column_mask", got.column_mask, want.column_mask, want);
        compare_field("living_rows", got.living_rows, want.living_rows, want);
        compare_field("living_cols", got.living_cols, want.living_cols, want);
        compare_field("nothing_to_do", got.nothing_to_do, want.nothing_to_do, want);
        compare_field("last_of_run", got.last_of_run, want.last_of_run, want);
    endtask

    // pixel driver
    always @(posedge clk)
    begin
        if (!rst_n)
            pix_if.valid <= 1'b0;
        else if (!pix_if.valid || pix_if.ready)
        begin
            if (!hold_sender && raster_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                pix_if.valid <= 1'b1;
                pix_if.data.pixel_value <= raster_q.pop_front();
            end
            else
                pix_if.valid <= 1'b0;
        end
    end

    // result receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: predict on every accepted pixel, check every accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_if.valid && pix_if.ready)
                scan_pixel(pix_if.data.pixel_value);
            if (res_if.valid && res_if.ready)
                check_result(res_if.data);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:     width_reg = IMG_W_W'(val);
            REG_IMAGE_HEIGHT:    height_reg = IMG_H_W'(val);
            REG_BYTES_PER_PIXEL: bpp_reg = BPP_W'(val);
            default: ;
        endcase
        @(negedge clk);
    endtask

    // wait until every pixel is taken and every owed result has come back
    task automatic wait_idle();
        while (raster_q.size() != 0 || pix_if.valid || owed_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [PIX_W-1:0] vary(input logic [PIX_W-1:0] base);
        case ($urandom_range(3))
            0:       return base;
            3:       return $urandom;
            default: return base ^ (32'd1 << $urandom_range(31));
        endcase
    endfunction

    function automatic int unsigned flat_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 25;
            2:       return 50;
            default: return 100;
        endcase
    endfunction

    // queue the first limit pixels of a random image with some flat rows and columns
    task automatic queue_image(input int unsigned fw, input int unsigned fh,
                               input int unsigned limit);
        logic [PIX_W-1:0] base;
        int unsigned      row_pct;
        int unsigned      col_pct;
        int unsigned      n;
        bit               flat_row;
        bit               flat_col [];
        base = $urandom;
        row_pct = flat_pct();
        col_pct = flat_pct();
        flat_col = new[fw];
        foreach (flat_col[i])
            flat_col[i] = ($urandom_range(99) < col_pct);
        n = 0;
        for (int y = 0; y < fh; y++)
        begin
            flat_row = ($urandom_range(99) < row_pct);
            for (int x = 0; x < fw; x++)
            begin
                if (n < limit)
                    raster_q.push_back((flat_row || flat_col[x]) ? base : vary(base));
                n++;
            end
        end
    endtask

    // pixels that close the frame under the current sizes
    task automatic queue_rest(output int unsigned count);
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] base;
        w = eff_width();
        h = eff_height();
        base = $urandom;
        count = (col_pos + 1 >= w) ? 1 : w - col_pos;
        if (row_pos + 1 < h)
            count += (h - row_pos - 1) * w;
        repeat (count) raster_q.push_back(vary(base));
    endtask

    task automatic random_frame(output int unsigned sent);
        int unsigned fw;
        int unsigned fh;
        int unsigned total;
        int unsigned cut;
        int unsigned rest;
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick < 13)
            fw = $urandom_range(12, 1);
        else if (pick < 16)
            fw = $urandom_range(70, 60);
        else if (pick < 18)
            fw = 0;
        else
            fw = $urandom_range(40, 13);
        pick = $urandom_range(9);
        if (pick < 8)
            fh = $urandom_range(5, 1);
        else if (pick == 8)
            fh = 0;
        else
            fh = $urandom_range(9, 6);
        write_reg(REG_IMAGE_WIDTH, fw);
        write_reg(REG_IMAGE_HEIGHT, fh);
        write_reg(REG_BYTES_PER_PIXEL, $urandom_range(7));
        fw = eff_width();
        fh = eff_height();
        total = fw * fh;
        if (total > 2 && $urandom_range(4) == 0)
        begin
            // resize part way through; the width only ever shrinks inside a frame
            cut = $urandom_range(total - 1, 1);
            queue_image(fw, fh, cut);
            wait_idle();
            case ($urandom_range(2))
                0:       write_reg(REG_IMAGE_WIDTH, $urandom_range(fw, 1));
                1:       write_reg(REG_IMAGE_HEIGHT, $urandom_range(8));
                default: write_reg(REG_BYTES_PER_PIXEL, $urandom_range(7));
            endcase
            queue_rest(rest);
            sent = cut + rest;
        end
        else
        begin
            queue_image(fw, fh, total);
            sent = total;
        end
        wait_idle();
    endtask

    initial
    begin
        int unsigned phase_pixels;
        int unsigned sent;
        pix_if.valid = 1'b0;
        pix_if.data = '0;
        res_if.ready = 1'b0;
        foreach (col_ref[i])
            col_ref[i] = '0;
        foreach (col_live[i])
            col_live[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single pixel frame
        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 1);
        write_reg(REG_BYTES_PER_PIXEL, 4);
        raster_q.push_back(32'hFFFF_FFFF);
        wait_idle();

        // every row and column alive in the low byte, noise above it
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_BYTES_PER_PIXEL, 1);
        raster_q.push_back(32'h0000_0000);
        raster_q.push_back(32'hAB00_0001);
        raster_q.push_back(32'h1200_0001);
        raster_q.push_back(32'hFF00_0000);
        wait_idle();

        // zero bytes compared: everything is flat
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_BYTES_PER_PIXEL, 0);
        repeat (6) raster_q.push_back($urandom);
        wait_idle();

        // width and height shrink mid-frame, live column left beyond the new width
        write_reg(REG_IMAGE_WIDTH, 4);
        write_reg(REG_IMAGE_HEIGHT, 3);
        write_reg(REG_BYTES_PER_PIXEL, 7);
        raster_q.push_back(32'd10);
        raster_q.push_back(32'd10);
        raster_q.push_back(32'd20);
        raster_q.push_back(32'd30);
        raster_q.push_back(32'd10);
        raster_q.push_back(32'd11);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 2);
        write_reg(REG_IMAGE_HEIGHT, 0);
        raster_q.push_back(32'd99);
        wait_idle();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 69 : 0;
            recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 35 : 0;
            phase_pixels = 0;
            if (phase == 1)
            begin
                // sender holds mid-frame until the owed results have drained
                write_reg(REG_IMAGE_WIDTH, 8);
                write_reg(REG_IMAGE_HEIGHT, 4);
                write_reg(REG_BYTES_PER_PIXEL, 4);
                queue_image(8, 4, 32);
                while (owed_results.size() == 0)
                    @(negedge clk);
                hold_sender = 1'b1;
                while (owed_results.size() != 0)
                    @(negedge clk);
                hold_sender = 1'b0;
                wait_idle();
                phase_pixels += 32;
            end
            while (phase_pixels < PHASE_PIXELS)
            begin
                random_frame(sent);
                phase_pixels += sent;
            end
        end

        // sizes written above their limits, then cut down part way through the first row
        write_reg(REG_IMAGE_WIDTH, 4095);
        write_reg(REG_IMAGE_HEIGHT, 8191);
        write_reg(REG_BYTES_PER_PIXEL, 4);
        queue_image(40, 1, 40);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 40);
        write_reg(REG_IMAGE_HEIGHT, 2);
        queue_rest(sent);
        wait_idle();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (owed_results.size() != 0)
            report_mismatch($sformatf("%0d results never came", owed_results.size()));
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// File: filelist.f
rtl/urcd_pkg.sv
rtl/urcd_chan_if.sv
rtl/urcd_col_track.sv
rtl/urcd_out_fifo.sv
rtl/uniform_row_column_detector_top.sv
verif/testbench.sv
